FILE: hw/rtl/sdq_pkg.sv
`timescale 1ns / 1ps

package sdq_pkg;

  localparam int DQ_DEPTH  = 64;
  localparam int DQ_IDX_W  = $clog2(DQ_DEPTH);
  localparam int DQ_CNT_W  = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_LOOKUP    = 3'd4,
    OP_MAX       = 3'd5,
    OP_MIN       = 3'd6,
    OP_LENGTH    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [DQ_DATA_W-1:0]  value;
  } req_beat_t;

  typedef struct packed {
    logic signed [DQ_DATA_W-1:0]  answer;
    logic [DQ_CNT_W-1:0]          count_after;
    status_t                      status;
  } rsp_beat_t;

  // ring slot of the k-th value counted from base
  function automatic logic [DQ_IDX_W-1:0] ring_slot(input logic [DQ_IDX_W-1:0] base,
                                                    input logic [DQ_CNT_W-1:0] k);
    logic [DQ_CNT_W:0] sum;
    logic [DQ_CNT_W:0] wrapped;
    sum = {{(DQ_CNT_W + 1 - DQ_IDX_W){1'b0}}, base} + {1'b0, k};
    if (sum >= (DQ_CNT_W + 1)'(DQ_DEPTH)) begin
      wrapped = sum - (DQ_CNT_W + 1)'(DQ_DEPTH);
    end else begin
      wrapped = sum;
    end
    return wrapped[DQ_IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/searchable_deque.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a 64-entry ring
// memory, with push/pop at either end and whole-store lookup, maximum, minimum
// and length requests. One request is taken at a time: req_stall is high from
// the cycle after a beat is taken until its response is loaded into the output
// register, while a finished response may still wait on rsp_stall. Push, pop
// and length go straight to the response without a scan; lookup and max scan
// the stored values once and min scans them twice. The scans use the single
// registered read port of the entry memory, read once per cycle, and feed one
// shared signed compare unit; min runs a max pass first, since its start value
// is that maximum. Max of an empty or all-negative store answers 0. Pushes
// into a full store and pops from an empty one leave the store as it is and
// report it in status.

module searchable_deque (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sdq_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sdq_pkg::rsp_beat_t rsp
);

  import sdq_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [DQ_DATA_W-1:0] mem [DQ_DEPTH];
  logic signed [DQ_DATA_W-1:0] rd_data;
  logic                        rd_vld;

  logic [DQ_IDX_W-1:0]         head;
  logic [DQ_CNT_W-1:0]         count;
  op_t                         cur_op;
  logic signed [DQ_DATA_W-1:0] key;
  logic signed [DQ_DATA_W-1:0] best;
  logic                        found;
  logic                        pass;
  logic [DQ_CNT_W-1:0]         issue_idx;
  logic signed [DQ_DATA_W-1:0] res_answer;
  status_t                     res_status;

  logic                        req_take;
  logic                        rsp_free;
  logic                        is_full;
  logic                        is_empty;
  logic                        is_scan_op;
  logic                        mem_we;
  logic [DQ_IDX_W-1:0]         mem_waddr;
  logic                        mem_re;
  logic [DQ_IDX_W-1:0]         rd_addr;
  logic                        scan_end;
  logic                        scan_last;
  logic [DQ_IDX_W-1:0]         head_dec;
  logic [DQ_IDX_W-1:0]         head_inc;

  // shared compare unit
  logic signed [DQ_DATA_W-1:0] cmp_b;
  logic                        cmp_gt;
  logic                        cmp_lt;
  logic                        cmp_eq;

  assign req_take   = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign is_full    = (count == DQ_CNT_W'(DQ_DEPTH));
  assign is_empty   = (count == '0);
  assign is_scan_op = (req.operation == OP_LOOKUP) || (req.operation == OP_MAX) ||
                      (req.operation == OP_MIN);
  assign head_dec   = ring_slot(head, DQ_CNT_W'(DQ_DEPTH - 1));
  assign head_inc   = ring_slot(head, DQ_CNT_W'(1));
  assign rd_addr    = ring_slot(head, issue_idx);
  assign scan_last  = (cur_op != OP_MIN) || pass;

  assign cmp_b  = (cur_op == OP_LOOKUP) ? key : best;
  assign cmp_gt = rd_data > cmp_b;
  assign cmp_lt = rd_data < cmp_b;
  assign cmp_eq = rd_data == cmp_b;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = is_scan_op ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end && scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    mem_re    = 1'b0;
    scan_end  = 1'b0;
    unique case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_SCAN: begin
        mem_re   = (issue_idx != count);
        scan_end = (issue_idx == count) && !rd_vld;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_dec;
    if (req_take && !is_full) begin
      if (req.operation == OP_PUSH_HEAD) begin
        mem_we = 1'b1;
      end else if (req.operation == OP_PUSH_TAIL) begin
        mem_we    = 1'b1;
        mem_waddr = ring_slot(head, count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= req.value;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= mem_re;
      if (req_take) begin
        unique case (req.operation)
          OP_PUSH_HEAD: begin
            if (!is_full) begin
              head  <= head_dec;
              count <= count + DQ_CNT_W'(1);
            end
          end
          OP_PUSH_TAIL: begin
            if (!is_full) begin
              count <= count + DQ_CNT_W'(1);
            end
          end
          OP_POP_HEAD: begin
            if (!is_empty) begin
              head  <= head_inc;
              count <= count - DQ_CNT_W'(1);
            end
          end
          OP_POP_TAIL: begin
            if (!is_empty) begin
              count <= count - DQ_CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_op     <= req.operation;
      key        <= req.value;
      best       <= '0;
      found      <= 1'b0;
      pass       <= 1'b0;
      issue_idx  <= '0;
      res_answer <= '0;
      res_status <= STAT_OK;
      case (req.operation) inside
        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
          if (is_full) begin
            res_status <= STAT_FULL;
          end
        end
        OP_POP_HEAD, OP_POP_TAIL: begin
          if (is_empty) begin
            res_status <= STAT_EMPTY;
          end
        end
        OP_LENGTH: res_answer <= DQ_DATA_W'(count);
        default: ;
      endcase
    end else if (state == ST_SCAN) begin
      if (mem_re) begin
        issue_idx <= issue_idx + DQ_CNT_W'(1);
      end
      if (rd_vld) begin
        if (cur_op == OP_LOOKUP) begin
          if (cmp_eq) begin
            found <= 1'b1;
          end
        end else if (!pass) begin
          if (cmp_gt) begin
            best <= rd_data;
          end
        end else if (cmp_lt) begin
          best <= rd_data;
        end
      end
      if (scan_end) begin
        if (scan_last) begin
          res_answer <= (cur_op == OP_LOOKUP) ? DQ_DATA_W'(found) : best;
        end else begin
          // second pass for min, starting from the max just found
          pass      <= 1'b1;
          issue_idx <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      rsp.answer      <= res_answer;
      rsp.count_after <= count;
      rsp.status      <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DQ_CNT_W'(DQ_DEPTH))
    else $error("stored count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_FULL |-> rsp.count_after == DQ_CNT_W'(DQ_DEPTH))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_EMPTY |-> rsp.count_after == '0)
    else $error("empty status with values stored");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ST_SCAN)
    else $error("read data outside a scan");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    req_take && !is_full &&
    (req.operation == OP_PUSH_HEAD || req.operation == OP_PUSH_TAIL)
    |=> count == $past(count) + DQ_CNT_W'(1))
    else $error("accepted push did not grow the store");

endmodule

FILE: tb/sv/searchable_deque_test.sv
`timescale 1ns / 1ps

module searchable_deque_test;
  import sdq_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 2 * DQ_DEPTH + 16;
  localparam int MAX_PRINTED  = 100;

  localparam logic signed [DQ_DATA_W-1:0] MOST_NEG = {1'b1, {(DQ_DATA_W-1){1'b0}}};
  localparam logic signed [DQ_DATA_W-1:0] MOST_POS = {1'b0, {(DQ_DATA_W-1){1'b1}}};

  localparam int VALS_ANY      = 0;
  localparam int VALS_SMALL    = 1;
  localparam int VALS_NEGATIVE = 2;
  localparam int VALS_POSITIVE = 3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_beat_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_beat_t rsp;

  searchable_deque uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the deque contents
  logic signed [DQ_DATA_W-1:0] shadow_slots [DQ_DEPTH];
  int shadow_head  = 0;
  int shadow_count = 0;

  rsp_beat_t pending_answers[$];
  rsp_beat_t want_rsp;
  int        errors      = 0;
  longint    cycle_count = 0;
  int        send_calm   = 0;
  int        stall_calm  = 0;
  int        stall_left  = 0;

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DQ_DATA_W-1:0] largest_held();
    logic signed [DQ_DATA_W-1:0] best;
    logic signed [DQ_DATA_W-1:0] v;
    best = '0;
    for (int k = 0; k < shadow_count; k++) begin
      v = shadow_slots[(shadow_head + k) % DQ_DEPTH];
      if (v > best) best = v;
    end
    return best;
  endfunction

  function automatic rsp_beat_t apply_request(input req_beat_t r);
    rsp_beat_t o;
    logic signed [DQ_DATA_W-1:0] best;
    logic signed [DQ_DATA_W-1:0] v;
    o.answer = '0;
    o.status = STAT_OK;
    case (r.operation)
      OP_PUSH_HEAD: begin
        if (shadow_count >= DQ_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          shadow_head = (shadow_head + DQ_DEPTH - 1) % DQ_DEPTH;
          shadow_slots[shadow_head] = r.value;
          shadow_count++;
        end
      end
      OP_PUSH_TAIL: begin
        if (shadow_count >= DQ_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          shadow_slots[(shadow_head + shadow_count) % DQ_DEPTH] = r.value;
          shadow_count++;
        end
      end
      OP_POP_HEAD: begin
        if (shadow_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DQ_DEPTH;
          shadow_count--;
        end
      end
      OP_POP_TAIL: begin
        if (shadow_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      OP_LOOKUP: begin
        for (int k = 0; k < shadow_count; k++) begin
          if (shadow_slots[(shadow_head + k) % DQ_DEPTH] == r.value) o.answer = 1;
        end
      end
      OP_MAX: begin
        o.answer = largest_held();
      end
      OP_MIN: begin
        // min starts from the max, itself floored at zero
        best = largest_held();
        for (int k = 0; k < shadow_count; k++) begin
          v = shadow_slots[(shadow_head + k) % DQ_DEPTH];
          if (v < best) best = v;
        end
        o.answer = best;
      end
      default: begin
        o.answer = shadow_count;
      end
    endcase
    o.count_after = DQ_CNT_W'(shadow_count);
    return o;
  endfunction

  function automatic logic signed [DQ_DATA_W-1:0] pick_value(input int flavor);
    logic [DQ_DATA_W-1:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: return MOST_NEG;
        1: return MOST_POS;
        2: return '0;
        default: return -1;
      endcase
    end
    case (flavor)
      VALS_SMALL:    return $signed(DQ_DATA_W'($urandom_range(0, 16))) - 8;
      VALS_NEGATIVE: return {1'b1, raw[DQ_DATA_W-2:0]};
      VALS_POSITIVE: return {1'b0, raw[DQ_DATA_W-2:0]};
      default:       return raw;
    endcase
  endfunction

  function automatic logic signed [DQ_DATA_W-1:0] pick_key(input int flavor);
    if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
      return shadow_slots[(shadow_head + $urandom_range(0, shadow_count - 1)) % DQ_DEPTH];
    end
    return pick_value(flavor);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
  endtask

  task automatic send_request(input op_t op, input logic signed [DQ_DATA_W-1:0] value);
    req_beat_t beat;
    int gap;
    beat.operation = op;
    beat.value = value;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
    end
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= beat;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_answers.push_back(apply_request(beat));
  endtask

  task automatic test_empty_store();
    send_request(OP_POP_HEAD, $urandom);
    send_request(OP_POP_TAIL, $urandom);
    send_request(OP_LOOKUP, '0);
    send_request(OP_MAX, $urandom);
    send_request(OP_MIN, $urandom);
    send_request(OP_LENGTH, $urandom);
  endtask

  task automatic test_extreme_values();
    send_request(OP_PUSH_TAIL, MOST_NEG);
    send_request(OP_PUSH_HEAD, -1);
    send_request(OP_MAX, '0);
    send_request(OP_MIN, '0);
    send_request(OP_LOOKUP, MOST_NEG);
    send_request(OP_LOOKUP, '0);
    send_request(OP_PUSH_TAIL, MOST_POS);
    send_request(OP_MAX, '1);
    send_request(OP_MIN, '1);
    send_request(OP_LENGTH, MOST_POS);
    send_request(OP_POP_HEAD, MOST_NEG);
    send_request(OP_POP_TAIL, '0);
    send_request(OP_POP_HEAD, '1);
    send_request(OP_LENGTH, '0);
  endtask

  task automatic test_positive_min();
    send_request(OP_PUSH_HEAD, 5);
    send_request(OP_PUSH_HEAD, 9);
    send_request(OP_MIN, '0);
    send_request(OP_POP_TAIL, '0);
    send_request(OP_POP_TAIL, '0);
  endtask

  task automatic test_full_store(input int flavor);
    while (shadow_count < DQ_DEPTH) begin
      send_request($urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL, pick_value(flavor));
    end
    send_request(OP_PUSH_HEAD, pick_value(flavor));
    send_request(OP_PUSH_TAIL, pick_value(flavor));
    send_request(OP_LOOKUP, pick_key(flavor));
    send_request(OP_LOOKUP, pick_value(flavor));
    send_request(OP_MAX, $urandom);
    send_request(OP_MIN, $urandom);
    send_request(OP_LENGTH, $urandom);
    while (shadow_count > 0) begin
      send_request($urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL, $urandom);
    end
    send_request(OP_POP_TAIL, $urandom);
    send_request(OP_POP_HEAD, $urandom);
  endtask

  task automatic test_random_mix(input int total);
    int sent;
    int phase_len;
    int push_pct;
    int flavor;
    int roll;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      flavor = $urandom_range(VALS_ANY, VALS_POSITIVE);
      for (int i = 0; i < phase_len && sent < total; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_request(op_t'($urandom_range(0, 7)), $urandom);
        end else if (roll < 60) begin
          if ($urandom_range(0, 99) < push_pct) begin
            send_request($urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL,
                         pick_value(flavor));
          end else begin
            send_request($urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL, $urandom);
          end
        end else if (roll < 75) begin
          send_request(OP_LOOKUP, pick_key(flavor));
        end else if (roll < 85) begin
          send_request(OP_MAX, $urandom);
        end else if (roll < 95) begin
          send_request(OP_MIN, $urandom);
        end else begin
          send_request(OP_LENGTH, $urandom);
        end
        sent++;
      end
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_calm > 0) begin
      rsp_stall <= 1'b0;
      stall_calm <= stall_calm - 1;
    end else begin
      rsp_stall <= 1'b0;
      if ($urandom_range(0, 99) == 0) begin
        stall_calm <= $urandom_range(50, 200);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("response with nothing outstanding, answer", rsp.answer, 0);
      end else begin
        want_rsp = pending_answers.pop_front();
        if (rsp.answer !== want_rsp.answer) begin
          report_mismatch("answer", rsp.answer, want_rsp.answer);
        end
        if (rsp.count_after !== want_rsp.count_after) begin
          report_mismatch("count_after", rsp.count_after, want_rsp.count_after);
        end
        if (rsp.status !== want_rsp.status) begin
          report_mismatch("status", rsp.status, want_rsp.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_extreme_values();
    test_positive_min();
    test_full_store(VALS_ANY);
    test_full_store(VALS_NEGATIVE);
    test_random_mix(1030);

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
